FILE: rtl/array_stack_bag_engine_defines.svh
// ----------------------------------------------------------------------------
// Array stack and bag engine assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef ARRAY_STACK_BAG_ENGINE_DEFINES_SVH
`define ARRAY_STACK_BAG_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASBE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("asbe port check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("asbe port check failed");

`endif

FILE: rtl/asbe_pkg.sv
// ----------------------------------------------------------------------------
// Array stack and bag engine package
// Types and constants shared by the cells, the top level and the checker.
// ----------------------------------------------------------------------------
package asbe_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WIDTH_DEF = 32;

    localparam int ACTION_W = 4;
    localparam int POS_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH         = 4'd0,
        ACT_POP          = 4'd1,
        ACT_TOP          = 4'd2,
        ACT_GET          = 4'd3,
        ACT_PUT          = 4'd4,
        ACT_REMOVE_AT    = 4'd5,
        ACT_SWAP         = 4'd6,
        ACT_REMOVE_VALUE = 4'd7,
        ACT_CONTAINS     = 4'd8
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        WR_LOAD,
        WR_SHIFT,
        WR_SWAP
    } t_wr_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic     wr_en;
        t_wr_kind wr_kind;
        logic     match_value;
    } t_cell_ctrl;

endpackage

FILE: rtl/array_stack_bag_engine.sv
// A command accepted in S_IDLE steps through S_SCAN and S_APPLY; the result is registered at the end of S_APPLY.
// A new command is taken only in S_IDLE; busy stays high through S_SCAN and S_APPLY.
// The chain moves one cell per cycle, so every lookup runs through all cells in S_SCAN before the update.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset clears the count, the controller and the strobe; entries stay unknown until written.
// ----------------------------------------------------------------------------
// Array stack and bag engine
// Bounded store of DEPTH entries used as a stack and as a bag. A row of cells
// resolves indexed reads and value searches, then updates in the S_APPLY state.
// ----------------------------------------------------------------------------
module array_stack_bag_engine #(
    parameter int DEPTH = asbe_pkg::DEPTH_DEF,
    parameter int WIDTH = asbe_pkg::WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [asbe_pkg::ACTION_W-1:0] i_action,
    input  logic [asbe_pkg::POS_W-1:0]    i_position,
    input  logic [asbe_pkg::POS_W-1:0]    i_second_position,
    input  logic [asbe_pkg::VALUE_W-1:0]  i_item_value,
    output logic                          o_valid,
    output logic [asbe_pkg::VALUE_W-1:0]  o_read_value,
    output logic                          o_found,
    output logic [asbe_pkg::STATUS_W-1:0] o_status,
    output logic [asbe_pkg::COUNT_W-1:0]  o_item_count,
    output logic                          o_is_empty
);
    import asbe_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int IDX_W = $clog2(DEPTH);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_scan, n_scan;
    logic [CNT_W-1:0] r_count, n_count;
    t_action          r_action;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_pos2;
    logic [WIDTH-1:0] r_value;

    logic                 r_valid;
    logic [VALUE_W-1:0]   r_read_value, n_read_value;
    logic                 r_found, n_found;
    t_status              r_status, n_status;
    logic [COUNT_W-1:0]   r_item_count;
    logic                 r_is_empty;

    logic       accept;
    logic       apply;
    t_cell_ctrl cell_ctrl;
    t_wr_kind   wr_kind;
    logic       wr_req;

    logic [KEY_W-1:0] key_cnt;
    logic [KEY_W-1:0] key_p;
    logic [KEY_W-1:0] key_q;
    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] key_w;
    logic             p_ok;
    logic             q_ok;
    logic             is_full;
    logic             is_zero;

    logic [WIDTH-1:0] w_entry [DEPTH];
    logic             w_hit   [DEPTH+1];
    logic [WIDTH-1:0] w_dat_a [DEPTH+1];
    logic [IDX_W-1:0] w_idx   [DEPTH+1];
    logic [WIDTH-1:0] w_dat_b [DEPTH+1];

    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_scan == IDX_W'(DEPTH - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy  = 1'b1;
        apply = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
            end
            S_SCAN: begin
                busy = 1'b1;
            end
            S_APPLY: begin
                apply = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    assign n_scan = (r_state == S_SCAN) ? r_scan + IDX_W'(1) : '0;

    assign key_cnt = KEY_W'(r_count);
    assign key_p   = KEY_W'(r_pos);
    assign key_q   = KEY_W'(r_pos2);
    assign p_ok    = key_p < key_cnt;
    assign q_ok    = key_q < key_cnt;
    assign is_full = (r_count == CNT_W'(DEPTH));
    assign is_zero = (r_count == '0);
    assign key_a   = (r_action == ACT_TOP) ? key_cnt - KEY_W'(1) : key_p;

    always_comb begin
        n_read_value = '0;
        n_found      = 1'b0;
        n_status     = ST_OK;
        n_count      = r_count;
        wr_req       = 1'b0;
        wr_kind      = WR_LOAD;
        key_w        = key_p;
        case (r_action)
            ACT_PUSH: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_req  = 1'b1;
                    key_w   = key_cnt;
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_POP: begin
                if (is_zero) begin
                    n_status = ST_BAD;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            ACT_TOP: begin
                if (is_zero) begin
                    n_status = ST_BAD;
                end else begin
                    n_read_value = VALUE_W'(w_dat_a[0]);
                end
            end
            ACT_GET: begin
                if (!p_ok) begin
                    n_status = ST_BAD;
                end else begin
                    n_read_value = VALUE_W'(w_dat_a[0]);
                end
            end
            ACT_PUT: begin
                if (!p_ok) begin
                    n_status = ST_BAD;
                end else begin
                    wr_req = 1'b1;
                end
            end
            ACT_REMOVE_AT: begin
                if (!p_ok) begin
                    n_status = ST_BAD;
                end else begin
                    wr_req  = 1'b1;
                    wr_kind = WR_SHIFT;
                    n_count = r_count - CNT_W'(1);
                end
            end
            ACT_SWAP: begin
                if (!p_ok || !q_ok) begin
                    n_status = ST_BAD;
                end else begin
                    wr_req  = 1'b1;
                    wr_kind = WR_SWAP;
                end
            end
            ACT_REMOVE_VALUE: begin
                if (w_hit[0]) begin
                    n_found = 1'b1;
                    wr_req  = 1'b1;
                    wr_kind = WR_SHIFT;
                    key_w   = KEY_W'(w_idx[0]);
                    n_count = r_count - CNT_W'(1);
                end
            end
            ACT_CONTAINS: begin
                n_found = w_hit[0];
            end
            default: begin
                n_status = ST_BAD;
            end
        endcase
    end

    assign cell_ctrl.wr_en       = apply && wr_req;
    assign cell_ctrl.wr_kind     = wr_kind;
    assign cell_ctrl.match_value = (r_action == ACT_REMOVE_VALUE) || (r_action == ACT_CONTAINS);

    assign w_hit[DEPTH]   = 1'b0;
    assign w_dat_a[DEPTH] = '0;
    assign w_idx[DEPTH]   = '0;
    assign w_dat_b[DEPTH] = '0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        asbe_cell #(
            .WIDTH (WIDTH),
            .KEY_W (KEY_W),
            .IDX_W (IDX_W),
            .INDEX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (cell_ctrl),
            .i_key_a    (key_a),
            .i_key_b    (key_q),
            .i_key_w    (key_w),
            .i_count    (key_cnt),
            .i_value    (r_value),
            .i_swap_a   (w_dat_a[0]),
            .i_swap_b   (w_dat_b[0]),
            .i_above    ((k == DEPTH - 1) ? w_entry[k] : w_entry[(k + 1) % DEPTH]),
            .i_hit_in   (w_hit[k + 1]),
            .i_dat_a_in (w_dat_a[k + 1]),
            .i_idx_in   (w_idx[k + 1]),
            .i_dat_b_in (w_dat_b[k + 1]),
            .o_entry    (w_entry[k]),
            .o_hit      (w_hit[k]),
            .o_dat_a    (w_dat_a[k]),
            .o_idx      (w_idx[k]),
            .o_dat_b    (w_dat_b[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_scan  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
            r_valid <= apply;
            if (apply) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= t_action'(i_action);
            r_pos    <= i_position;
            r_pos2   <= i_second_position;
            r_value  <= WIDTH'(i_item_value);
        end
        if (apply) begin
            r_read_value <= n_read_value;
            r_found      <= n_found;
            r_status     <= n_status;
            r_item_count <= COUNT_W'(n_count);
            r_is_empty   <= (n_count == '0);
        end
    end

    assign o_valid      = r_valid;
    assign o_read_value = r_read_value;
    assign o_found      = r_found;
    assign o_status     = r_status;
    assign o_item_count = r_item_count;
    assign o_is_empty   = r_is_empty;

endmodule

FILE: rtl/asbe_cell.sv
// ----------------------------------------------------------------------------
// Array stack and bag engine cell
// Holds one entry, passes the lookup chain down to its lower neighbor every
// cycle, and takes a load, a shift from above or a swap value on update.
// ----------------------------------------------------------------------------
module asbe_cell #(
    parameter int WIDTH = 32,
    parameter int KEY_W = 5,
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  logic                  i_clk,
    input  asbe_pkg::t_cell_ctrl  i_ctrl,
    input  logic [KEY_W-1:0]      i_key_a,
    input  logic [KEY_W-1:0]      i_key_b,
    input  logic [KEY_W-1:0]      i_key_w,
    input  logic [KEY_W-1:0]      i_count,
    input  logic [WIDTH-1:0]      i_value,
    input  logic [WIDTH-1:0]      i_swap_a,
    input  logic [WIDTH-1:0]      i_swap_b,
    input  logic [WIDTH-1:0]      i_above,
    input  logic                  i_hit_in,
    input  logic [WIDTH-1:0]      i_dat_a_in,
    input  logic [IDX_W-1:0]      i_idx_in,
    input  logic [WIDTH-1:0]      i_dat_b_in,
    output logic [WIDTH-1:0]      o_entry,
    output logic                  o_hit,
    output logic [WIDTH-1:0]      o_dat_a,
    output logic [IDX_W-1:0]      o_idx,
    output logic [WIDTH-1:0]      o_dat_b
);
    import asbe_pkg::*;

    localparam logic [KEY_W-1:0] MyKey = KEY_W'(INDEX);
    localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

    logic [WIDTH-1:0] r_entry, n_entry;
    logic             r_hit, n_hit;
    logic [WIDTH-1:0] r_dat_a, n_dat_a;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [WIDTH-1:0] r_dat_b, n_dat_b;
    logic             hit_a;
    logic             hit_b;

    always_comb begin
        if (i_ctrl.match_value) begin
            hit_a = (r_entry == i_value) && (MyKey < i_count);
        end else begin
            hit_a = (MyKey == i_key_a);
        end
        hit_b = (MyKey == i_key_b);
    end

    // The lowest matching cell wins because it overrides what comes from above.
    always_comb begin
        n_hit   = hit_a | i_hit_in;
        n_dat_a = hit_a ? r_entry : i_dat_a_in;
        n_idx   = hit_a ? MyIdx : i_idx_in;
        n_dat_b = hit_b ? r_entry : i_dat_b_in;
    end

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.wr_en) begin
            case (i_ctrl.wr_kind)
                WR_LOAD: begin
                    if (MyKey == i_key_w) begin
                        n_entry = i_value;
                    end
                end
                WR_SHIFT: begin
                    if (MyKey >= i_key_w) begin
                        n_entry = i_above;
                    end
                end
                WR_SWAP: begin
                    if (hit_a) begin
                        n_entry = i_swap_b;
                    end else if (hit_b) begin
                        n_entry = i_swap_a;
                    end
                end
                default: begin
                    n_entry = r_entry;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_hit   <= n_hit;
        r_dat_a <= n_dat_a;
        r_idx   <= n_idx;
        r_dat_b <= n_dat_b;
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;
    assign o_dat_a = r_dat_a;
    assign o_idx   = r_idx;
    assign o_dat_b = r_dat_b;

endmodule

FILE: rtl/asbe_checker.sv
// ----------------------------------------------------------------------------
// Array stack and bag engine port checker
// Watches the top-level ports for command and result consistency over time.
// ----------------------------------------------------------------------------
`include "array_stack_bag_engine_defines.svh"

module asbe_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [asbe_pkg::VALUE_W-1:0]  o_read_value,
    input logic                          o_found,
    input logic [asbe_pkg::STATUS_W-1:0] o_status,
    input logic [asbe_pkg::COUNT_W-1:0]  o_item_count,
    input logic                          o_is_empty
);
    import asbe_pkg::*;

    `ASBE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `ASBE_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid)
    `ASBE_ASSERT_NOW(a_empty_count, o_valid && o_is_empty, o_item_count == '0)
    `ASBE_ASSERT_NOW(a_found_ok, o_valid && o_found, o_status == ST_OK)
    `ASBE_ASSERT_NOW(a_full_no_read, o_valid && (o_status == ST_FULL), o_read_value == '0)

endmodule

bind array_stack_bag_engine asbe_checker u_asbe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_read_value (o_read_value),
    .o_found      (o_found),
    .o_status     (o_status),
    .o_item_count (o_item_count),
    .o_is_empty   (o_is_empty)
);
